>>> hdl/indexed_array_list_defines.svh
// Assertion macros for the indexed array list RTL.
`ifndef INDEXED_ARRAY_LIST_DEFINES_SVH
`define INDEXED_ARRAY_LIST_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define IAL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("indexed_array_list assertion failed");
// Check a property on every clock edge, reset included.
`define IAL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("indexed_array_list assertion failed");
`else
`define IAL_ASSERT(lbl, prop)
`define IAL_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> hdl/ial_pkg.sv
// Types and constants of the indexed array list.
package ial_pkg;

  // Store size and derived widths
  localparam int CAPACITY = 16;
  localparam int AW       = $clog2(CAPACITY);
  localparam int LW       = $clog2(CAPACITY + 1);
  localparam int XW       = LW + 1;
  localparam int DW       = 32;

  // Stream payload widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [2:0] {
    OP_READ       = 3'd0,
    OP_APPEND     = 3'd1,
    OP_INSERT     = 3'd2,
    OP_REMOVE_AT  = 3'd3,
    OP_REMOVE_VAL = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_RANGE     = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_WAIT,
    ST_UP_MOVE,
    ST_PUT,
    ST_SEARCH,
    ST_DN_MOVE,
    ST_RESULT
  } state_e;

endpackage

>>> hdl/ial_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ial_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/indexed_array_list.sv
// Indexed array list: ordered list of signed words with insert/remove by index and value.
// Each walk moves one store entry per cycle through one RAM port.
// One transaction at a time; the next is accepted in the cycle after the result is set.
// Reset clears the element count and the handshake state; the store itself is not cleared.
`include "indexed_array_list_defines.svh"

module indexed_array_list (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [2:0] op, [6:3] position, [38:7] element, [39] zero
  input  logic [ial_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] data_out, [35:32] found_at, [37:36] status, [42:38] fill, [47:43] zero
  output logic [ial_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import ial_pkg::*;

  state_e          state_q, state_d;
  op_e             op_q, op_d;
  logic [3:0]      pos_q, pos_d;
  logic [DW-1:0]   elem_q, elem_d;
  logic [LW-1:0]   len_q, len_d;
  logic [AW-1:0]   k_q, k_d;
  logic [DW-1:0]   data_q, data_d;
  logic [AW-1:0]   found_q, found_d;
  status_e         status_q, status_d;
  logic            out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [DW-1:0]   ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [DW-1:0]   ram_rdata;

  logic            in_fire;
  logic            out_free;
  logic [XW-1:0]   pos_x, len_x, k_x;
  logic            pos_lt_len, pos_gt_len, pos_eq_len, not_full;
  logic            k1_lt_len, k2_lt_len, up_last, hit;

  // Element store
  ial_ram #(
    .WIDTH(DW),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (ram_we),
    .wr_addr_i(ram_waddr),
    .wr_data_i(ram_wdata),
    .rd_en_i  (ram_re),
    .rd_addr_i(ram_raddr),
    .rd_data_o(ram_rdata)
  );

  // Handshake
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Shared compare unit
  assign pos_x      = XW'(pos_q);
  assign len_x      = XW'(len_q);
  assign k_x        = XW'(k_q);
  assign pos_lt_len = pos_x < len_x;
  assign pos_gt_len = pos_x > len_x;
  assign pos_eq_len = pos_x == len_x;
  assign not_full   = len_x < XW'(CAPACITY);
  assign k1_lt_len  = (k_x + XW'(1)) < len_x;
  assign k2_lt_len  = (k_x + XW'(2)) < len_x;
  assign up_last    = (k_x - XW'(1)) == pos_x;
  assign hit        = (op_q == OP_REMOVE_AT) || (ram_rdata == elem_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        state_d = ST_RESULT;
        case (op_q)
          OP_READ:       if (pos_lt_len) state_d = ST_RD_WAIT;
          OP_INSERT:     if (!pos_gt_len && not_full && !pos_eq_len) state_d = ST_UP_MOVE;
          OP_REMOVE_AT:  if (pos_lt_len) state_d = ST_SEARCH;
          OP_REMOVE_VAL: if (len_q != '0) state_d = ST_SEARCH;
          default:       state_d = ST_RESULT;
        endcase
      end
      ST_RD_WAIT:  state_d = ST_RESULT;
      ST_UP_MOVE:  if (up_last) state_d = ST_PUT;
      ST_PUT:      state_d = ST_RESULT;
      ST_SEARCH: begin
        if (hit) begin
          state_d = k1_lt_len ? ST_DN_MOVE : ST_RESULT;
        end else if (!k1_lt_len) begin
          state_d = ST_RESULT;
        end
      end
      ST_DN_MOVE:  if (!k2_lt_len) state_d = ST_RESULT;
      ST_RESULT:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and store control
  always_comb begin
    op_d        = op_q;
    pos_d       = pos_q;
    elem_d      = elem_q;
    len_d       = len_q;
    k_d         = k_q;
    data_d      = data_q;
    found_d     = found_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = k_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = k_q;

    // Drop the result once taken
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d   = op_e'(s_axis_tdata[2:0]);
          pos_d  = s_axis_tdata[6:3];
          elem_d = s_axis_tdata[38:7];
        end
      end
      ST_DISPATCH: begin
        data_d   = '0;
        found_d  = '0;
        status_d = STS_OK;
        case (op_q)
          OP_READ: begin
            if (pos_lt_len) begin
              ram_re    = 1'b1;
              ram_raddr = AW'(pos_q);
            end else begin
              status_d = STS_RANGE;
            end
          end
          OP_APPEND: begin
            if (not_full) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(len_q);
              ram_wdata = elem_q;
              len_d     = len_q + LW'(1);
            end else begin
              status_d = STS_FULL;
            end
          end
          OP_INSERT: begin
            if (pos_gt_len) begin
              status_d = STS_RANGE;
            end else if (!not_full) begin
              status_d = STS_FULL;
            end else if (pos_eq_len) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(pos_q);
              ram_wdata = elem_q;
              len_d     = len_q + LW'(1);
            end else begin
              // Start the upward shift from the last element
              k_d       = AW'(len_q);
              ram_re    = 1'b1;
              ram_raddr = AW'(len_q - LW'(1));
            end
          end
          OP_REMOVE_AT: begin
            if (pos_lt_len) begin
              k_d       = AW'(pos_q);
              ram_re    = 1'b1;
              ram_raddr = AW'(pos_q);
            end else begin
              status_d = STS_RANGE;
            end
          end
          OP_REMOVE_VAL: begin
            if (len_q != '0) begin
              k_d       = '0;
              ram_re    = 1'b1;
              ram_raddr = '0;
            end else begin
              status_d = STS_NOT_FOUND;
            end
          end
          default: status_d = STS_RANGE;
        endcase
      end
      ST_RD_WAIT: begin
        data_d = ram_rdata;
      end
      ST_UP_MOVE: begin
        // Move one element up and fetch the one below
        ram_we    = 1'b1;
        ram_waddr = k_q;
        ram_wdata = ram_rdata;
        if (!up_last) begin
          ram_re    = 1'b1;
          ram_raddr = k_q - AW'(2);
          k_d       = k_q - AW'(1);
        end
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(pos_q);
        ram_wdata = elem_q;
        len_d     = len_q + LW'(1);
      end
      ST_SEARCH: begin
        if (hit) begin
          data_d  = ram_rdata;
          found_d = (op_q == OP_REMOVE_VAL) ? k_q : '0;
          if (k1_lt_len) begin
            ram_re    = 1'b1;
            ram_raddr = k_q + AW'(1);
          end else begin
            len_d = len_q - LW'(1);
          end
        end else if (k1_lt_len) begin
          ram_re    = 1'b1;
          ram_raddr = k_q + AW'(1);
          k_d       = k_q + AW'(1);
        end else begin
          status_d = STS_NOT_FOUND;
        end
      end
      ST_DN_MOVE: begin
        // Move one element down and fetch the next
        ram_we    = 1'b1;
        ram_waddr = k_q;
        ram_wdata = ram_rdata;
        if (k2_lt_len) begin
          ram_re    = 1'b1;
          ram_raddr = k_q + AW'(2);
          k_d       = k_q + AW'(1);
        end else begin
          len_d = len_q - LW'(1);
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {5'b0, 5'(len_q), status_q, 4'(found_q), data_q};
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    pos_q      <= pos_d;
    elem_q     <= elem_d;
    k_q        <= k_d;
    data_q     <= data_d;
    found_q    <= found_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
  end

  `IAL_ASSERT(a_len_bound, len_q <= LW'(CAPACITY))
  `IAL_ASSERT(a_len_change_at_end, (len_q != $past(len_q)) |-> (state_q == ST_RESULT))
  `IAL_ASSERT(a_accept_dispatch, in_fire |=> (state_q == ST_DISPATCH))
  `IAL_ASSERT(a_write_dense, ram_we |-> (XW'(ram_waddr) <= len_x))

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the indexed array list: directed and random requests.
module tb_top;
  import ial_pkg::*;

  // Op codes with no operation behind them
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 1750;
  localparam int CALM_TAIL    = 150;
  // Longest walk is a search plus removal over a full store
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;

  typedef struct {
    logic [31:0] data;
    logic [3:0]  found_at;
    status_e     status;
    logic [4:0]  fill;
  } list_reply_t;

  // Mirror of the list contents plus the replies still owed by the block
  class list_mirror;
    logic [31:0] items [CAPACITY];
    int          count;
    int          errors;
    list_reply_t expected_replies [$];

    function new();
      count  = 0;
      errors = 0;
    endfunction

    // Close the gap left by a removed entry
    function void drop_at(int at);
      int k;
      for (k = at; k + 1 < count; k++) items[k] = items[k + 1];
      count--;
    endfunction

    // Apply one accepted request and queue the reply it must produce
    function void note_request(logic [2:0] op, logic [3:0] pos, logic [31:0] elem);
      list_reply_t r;
      int          k;
      int          idx;
      bit          hit;
      r.data     = '0;
      r.found_at = '0;
      r.status   = STS_OK;
      idx        = int'(pos);
      case (op)
        OP_READ: begin
          if (idx < count) r.data = items[idx];
          else r.status = STS_RANGE;
        end
        OP_APPEND: begin
          if (count < CAPACITY) begin
            items[count] = elem;
            count++;
          end else begin
            r.status = STS_FULL;
          end
        end
        OP_INSERT: begin
          // Range test wins over the full test
          if (idx > count) begin
            r.status = STS_RANGE;
          end else if (count >= CAPACITY) begin
            r.status = STS_FULL;
          end else begin
            for (k = count; k > idx; k--) items[k] = items[k - 1];
            items[idx] = elem;
            count++;
          end
        end
        OP_REMOVE_AT: begin
          if (idx < count) begin
            r.data = items[idx];
            drop_at(idx);
          end else begin
            r.status = STS_RANGE;
          end
        end
        OP_REMOVE_VAL: begin
          r.status = STS_NOT_FOUND;
          hit      = 1'b0;
          for (k = 0; k < count && !hit; k++) begin
            if (items[k] === elem) begin
              r.data     = items[k];
              r.found_at = k[3:0];
              r.status   = STS_OK;
              hit        = 1'b1;
              drop_at(k);
            end
          end
        end
        default: r.status = STS_RANGE;
      endcase
      r.fill = count[4:0];
      expected_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
    endfunction

    // Compare one result transaction with the oldest owed reply
    function void check_reply(logic [OUT_TDATA_W-1:0] beat);
      list_reply_t r;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual %h", $time, beat);
        return;
      end
      r = expected_replies.pop_front();
      compare_field("data_out", r.data, beat[31:0]);
      compare_field("found_at", 32'(r.found_at), 32'(beat[35:32]));
      compare_field("status", 32'(r.status), 32'(beat[37:36]));
      compare_field("fill", 32'(r.fill), 32'(beat[42:38]));
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tready = 1'b0;
  logic                   s_axis_tready;
  logic                   m_axis_tvalid;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  list_mirror board;
  bit         tail_calm  = 1'b0;
  bit         gaps_on    = 1'b1;
  int         add_weight = 50;

  indexed_array_list u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drive one request and hold it until the block takes it
  task automatic send_request(logic [2:0] op, logic [3:0] pos, logic [31:0] elem);
    s_axis_tdata  <= {1'b0, elem, pos, op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(op, pos, elem);
    if (!tail_calm && gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] random_element();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return 32'($urandom_range(0, 7));
    if (roll == 3) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  // Pick a request biased toward valid positions and present values
  task automatic random_request();
    int          roll;
    int          n;
    logic [2:0]  op;
    logic [3:0]  pos;
    logic [31:0] elem;
    n    = board.count;
    roll = $urandom_range(0, 99);
    if (roll < 2) op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    else if (roll < 14) op = OP_READ;
    else if ($urandom_range(0, 99) < add_weight) op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
    else op = $urandom_range(0, 1) ? OP_REMOVE_AT : OP_REMOVE_VAL;

    if ($urandom_range(0, 99) < 15) pos = 4'($urandom_range(0, 15));
    else if (op == OP_INSERT) pos = 4'($urandom_range(0, (n > 15) ? 15 : n));
    else if (n > 0) pos = 4'($urandom_range(0, n - 1));
    else pos = 4'($urandom_range(0, 15));

    if (op == OP_REMOVE_VAL && n > 0 && $urandom_range(0, 3) != 0)
      elem = board.items[$urandom_range(0, n - 1)];
    else
      elem = random_element();
    send_request(op, pos, elem);
  endtask

  // Receiver side: stall in random bursts until the calm tail
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!tail_calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Check every result transaction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_reply(m_axis_tdata);
  end

  initial begin
    int i;
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: every lookup and removal misses; an insert past the end and a spare op are refused
    send_request(OP_READ, 4'd0, 32'h0);
    send_request(OP_REMOVE_AT, 4'd0, 32'h0);
    send_request(OP_REMOVE_VAL, 4'd0, 32'h0);
    send_request(OP_INSERT, 4'd1, 32'h1);
    send_request(OP_SPARE_HI, 4'd15, 32'h7FFF_FFFF);
    // Fill with extremes, inserting at the front, middle and end
    send_request(OP_INSERT, 4'd0, 32'h8000_0000);
    send_request(OP_APPEND, 4'd0, 32'h7FFF_FFFF);
    send_request(OP_APPEND, 4'd0, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 4'd1, 32'h5555_5555);
    send_request(OP_INSERT, 4'd4, 32'hAAAA_AAAA);
    for (i = 1; i <= 11; i++) send_request(OP_APPEND, 4'd0, 32'(i));
    // Full list refuses additions
    send_request(OP_APPEND, 4'd0, 32'h1);
    send_request(OP_INSERT, 4'd0, 32'h2);
    // Last entry, then removals by index and by value
    send_request(OP_READ, 4'd15, 32'h0);
    send_request(OP_REMOVE_AT, 4'd15, 32'h0);
    send_request(OP_REMOVE_VAL, 4'd0, 32'hFFFF_FFFF);
    send_request(OP_REMOVE_VAL, 4'd0, 32'h1234_5678);
    send_request(OP_REMOVE_AT, 4'd0, 32'h0);

    // Hold off until every owed reply is back
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       add_weight = 80;
          1:       add_weight = 25;
          default: add_weight = 50;
        endcase
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      if (i == RANDOM_ITEMS - CALM_TAIL) tail_calm = 1'b1;
      random_request();
    end

    // Drain outstanding replies, then watch for strays
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("indexed_array_list: match");
    end else begin
      $display("indexed_array_list: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("indexed_array_list: mismatch");
    $finish;
  end

endmodule
